### src/eod_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eod_pkg;

    // history ring
    localparam int HISTORY_DEPTH = 64;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);

    // window limits and field widths
    localparam int MAX_WINDOW_LENGTH = 4096;
    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 17;
    localparam int LEN_W      = 13;
    localparam int THR_W      = 16;
    localparam int SUM_W      = 28;
    localparam int HSUM_W     = 22;
    localparam int AVG_W      = 16;
    localparam int IDX_W      = 16;
    localparam int OUT_DATA_W = IDX_W + 2 * AVG_W;

    // divider: quotient never needs more than AVG_W bits
    localparam int DIV_STEPS  = AVG_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    // apb
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    typedef enum logic [0:0] {
        REG_WINDOW_LENGTH = 1'b0,
        REG_THRESHOLD     = 1'b1
    } eod_reg_idx_t;

    typedef enum logic [2:0] {
        ST_ACCUM = 3'b001,
        ST_DIV   = 3'b010,
        ST_EMIT  = 3'b100
    } eod_state_t;

    // controller to datapath
    typedef struct packed {
        logic take;      // accept the sample on the input
        logic div_step;  // one restoring division step
        logic commit;    // load output word, update ring
    } eod_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic closing;   // the sample on the input closes its window
        logic out_free;  // output register can take a word this cycle
    } eod_sts_t;

endpackage

`default_nettype wire

### src/eod_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module eod_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/eod_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module eod_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire eod_pkg::eod_sts_t sts,
    output eod_pkg::eod_cmd_t    cmd
);

    import eod_pkg::*;

    localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(DIV_STEPS - 1);

    eod_state_t              state_reg, state_next;
    logic [STEP_CNT_W-1:0]   step_cnt_reg, step_cnt_next;

    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_ACCUM:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.take = 1'b1;
                    if (sts.closing)
                    begin
                        state_next    = ST_DIV;
                        step_cnt_next = '0;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step  = 1'b1;
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == STEP_LAST)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_ACCUM;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.out_free)
        else $error("commit while output register is occupied");

    a_close_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && sts.closing) |=> (state_reg == ST_DIV && step_cnt_reg == '0))
        else $error("closing sample did not start the divider");

    a_div_ends_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && step_cnt_reg == STEP_LAST) |=> state_reg == ST_EMIT)
        else $error("divider ran past its step count");

    a_commit_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> s_tready)
        else $error("input not reopened after commit");

endmodule

`default_nettype wire

### src/eod_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module eod_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire eod_pkg::eod_cmd_t                 cmd,
    output eod_pkg::eod_sts_t                      sts,
    input  wire logic signed [eod_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                              last_of_block,
    input  wire logic [eod_pkg::LEN_W-1:0]         window_length,
    input  wire logic [eod_pkg::THR_W-1:0]         threshold,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [eod_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic [0:0]                             m_tuser
);

    import eod_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WINDOW_LENGTH);

    // window accumulation
    logic [SUM_W-1:0]  win_sum_reg, win_sum_next;
    logic [LEN_W-1:0]  win_cnt_reg, win_cnt_next;
    logic              last_reg, last_next;

    // divider
    logic [LEN_W-1:0]  dvs_reg, dvs_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [AVG_W-1:0]  quo_reg, quo_next;

    // history
    logic [HSUM_W-1:0]        hist_sum_reg, hist_sum_next;
    logic [HIST_AW-1:0]       pos_reg, pos_next;
    logic [HISTORY_DEPTH-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]         win_ctr_reg, win_ctr_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [AVG_W-1:0]  out_avg_reg, out_avg_next;
    logic [AVG_W-1:0]  out_hist_reg, out_hist_next;
    logic              out_flag_reg, out_flag_next;

    logic signed [MAG_W-1:0] sample_x;
    logic [MAG_W-1:0]        mag;
    logic [LEN_W-1:0]        eff_len;
    logic [SUM_W-1:0]        sum_acc;
    logic [LEN_W-1:0]        cnt_acc;
    logic [LEN_W:0]          trial;
    logic [LEN_W:0]          trial_diff;
    logic [AVG_W-1:0]        ring_rdata;
    logic [AVG_W-1:0]        ring_old;
    logic [AVG_W-1:0]        hist_avg;
    logic signed [AVG_W+1:0] excess;

    assign sample_x = MAG_W'(sample);
    assign mag      = sample[SAMPLE_W-1] ? MAG_W'(-sample_x) : MAG_W'(sample_x);

    always_comb
    begin
        priority if (window_length == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (window_length > MAX_LEN)
        begin
            eff_len = MAX_LEN;
        end
        else
        begin
            eff_len = window_length;
        end
    end

    assign sum_acc     = win_sum_reg + SUM_W'(mag);
    assign cnt_acc     = win_cnt_reg + 1'b1;
    assign sts.closing = last_of_block || (cnt_acc >= eff_len);
    assign sts.out_free = !out_valid_reg || m_tready;

    // restoring division step; the top bits of the sum start below the divisor
    assign trial      = {rem_reg, quo_reg[AVG_W-1]};
    assign trial_diff = trial - (LEN_W + 1)'(dvs_reg);

    assign ring_old = valid_reg[pos_reg] ? ring_rdata : '0;
    assign hist_avg = AVG_W'(hist_sum_reg >> HIST_AW);
    assign excess   = $signed({2'b00, quo_reg}) - $signed({2'b00, hist_avg});

    always_comb
    begin
        win_sum_next   = win_sum_reg;
        win_cnt_next   = win_cnt_reg;
        last_next      = last_reg;
        dvs_next       = dvs_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        hist_sum_next  = hist_sum_reg;
        pos_next       = pos_reg;
        valid_next     = valid_reg;
        win_ctr_next   = win_ctr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_idx_next   = out_idx_reg;
        out_avg_next   = out_avg_reg;
        out_hist_next  = out_hist_reg;
        out_flag_next  = out_flag_reg;

        if (cmd.take)
        begin
            if (sts.closing)
            begin
                win_sum_next = '0;
                win_cnt_next = '0;
                last_next    = last_of_block;
                dvs_next     = cnt_acc;
                rem_next     = LEN_W'(sum_acc[SUM_W-1:AVG_W]);
                quo_next     = sum_acc[AVG_W-1:0];
            end
            else
            begin
                win_sum_next = sum_acc;
                win_cnt_next = cnt_acc;
            end
        end

        if (cmd.div_step)
        begin
            if (!trial_diff[LEN_W] && (trial >= (LEN_W + 1)'(dvs_reg)))
            begin
                rem_next = trial_diff[LEN_W-1:0];
                quo_next = {quo_reg[AVG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[LEN_W-1:0];
                quo_next = {quo_reg[AVG_W-2:0], 1'b0};
            end
        end

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
            out_idx_next   = win_ctr_reg;
            out_avg_next   = quo_reg;
            out_hist_next  = hist_avg;
            out_flag_next  = excess >= $signed({2'b00, threshold});
            if (last_reg)
            begin
                hist_sum_next = '0;
                pos_next      = '0;
                valid_next    = '0;
                win_ctr_next  = '0;
            end
            else
            begin
                hist_sum_next      = hist_sum_reg - HSUM_W'(ring_old) + HSUM_W'(quo_reg);
                pos_next           = pos_reg + 1'b1;
                valid_next[pos_reg] = 1'b1;
                win_ctr_next       = win_ctr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_sum_reg   <= '0;
            win_cnt_reg   <= '0;
            last_reg      <= 1'b0;
            hist_sum_reg  <= '0;
            pos_reg       <= '0;
            valid_reg     <= '0;
            win_ctr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_sum_reg   <= win_sum_next;
            win_cnt_reg   <= win_cnt_next;
            last_reg      <= last_next;
            hist_sum_reg  <= hist_sum_next;
            pos_reg       <= pos_next;
            valid_reg     <= valid_next;
            win_ctr_reg   <= win_ctr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvs_reg      <= dvs_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        out_idx_reg  <= out_idx_next;
        out_avg_reg  <= out_avg_next;
        out_hist_reg <= out_hist_next;
        out_flag_reg <= out_flag_next;
    end

    eod_ram #(
        .WIDTH (AVG_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.commit && !last_reg),
        .waddr (pos_reg),
        .wdata (quo_reg),
        .raddr (pos_reg),
        .rdata (ring_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_hist_reg, out_avg_reg, out_idx_reg};
    assign m_tuser  = out_flag_reg;

endmodule

`default_nettype wire

### src/energy_onset_detector_top.sv
`timescale 1ns / 1ps
`default_nettype none

// energy onset detector: takes signed q1.15 samples on the s_ stream and sums
// their magnitudes over windows of window_length samples (0 acts as 1, values
// above 4096 act as 4096); s_tlast closes a partial window and, once that
// window is reported, clears the history ring, its sum and the window index.
// each closed window yields one word on the m_ stream: its index, its average
// magnitude, the mean of the 64 previous averages (empty slots count as zero)
// and, in m_tuser, whether the average exceeds that mean by threshold or more.
// samples that do not close a window are taken one per cycle; a closing
// sample holds the input closed for its accept, for the bit-per-cycle
// restoring divider that forms the window average, and for one commit that
// also waits for the output register to drain. the history ring sits in a
// 64-entry ram with per-entry valid flops, so reset and end of block need no
// clearing pass. registers: window_length at 0x0, threshold at 0x4, to be
// written by the user only while the block is idle; the block does not enforce it

module energy_onset_detector_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [eod_pkg::SAMPLE_W-1:0]     s_tdata,  // [15:0] sample
    input  wire logic                             s_tlast,  // last_of_block
    // output stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [eod_pkg::OUT_DATA_W-1:0]        m_tdata,  // [15:0] window_index,
                                                            // [31:16] window_average,
                                                            // [47:32] history_average
    output logic [0:0]                            m_tuser,  // [0] is_outlier
    // configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [eod_pkg::APB_AW-1:0]       paddr,
    input  wire logic [eod_pkg::APB_DW-1:0]       pwdata,
    output logic [eod_pkg::APB_DW-1:0]            prdata,
    output logic                                  pready
);

    import eod_pkg::*;

    logic [LEN_W-1:0] window_length_reg, window_length_next;
    logic [THR_W-1:0] threshold_reg, threshold_next;
    eod_reg_idx_t     reg_sel;
    logic             cfg_write;
    eod_cmd_t         cmd;
    eod_sts_t         sts;

    // register index is the word address
    assign reg_sel   = eod_reg_idx_t'(paddr[APB_AW-1:2]);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        window_length_next = window_length_reg;
        threshold_next     = threshold_reg;
        if (cfg_write)
        begin
            unique case (reg_sel)
                REG_WINDOW_LENGTH: window_length_next = pwdata[LEN_W-1:0];
                REG_THRESHOLD:     threshold_next     = pwdata[THR_W-1:0];
                default:           window_length_next = window_length_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_WINDOW_LENGTH: prdata = APB_DW'(window_length_reg);
            REG_THRESHOLD:     prdata = APB_DW'(threshold_reg);
            default:           prdata = '0;
        endcase
    end

    // reset values: 1024 samples per window, threshold about 0.1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= LEN_W'(1024);
            threshold_reg     <= THR_W'(3277);
        end
        else
        begin
            window_length_reg <= window_length_next;
            threshold_reg     <= threshold_next;
        end
    end

    // sequencer: accumulate, divide, commit
    eod_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // window sums, divider, history ring and output register
    eod_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .sample        ($signed(s_tdata)),
        .last_of_block (s_tlast),
        .window_length (window_length_reg),
        .threshold     (threshold_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

endmodule

`default_nettype wire

### bench/energy_onset_detector_top_test.sv
`timescale 1ns / 1ps

module energy_onset_detector_top_test;
    import eod_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 24;  // closing sample: accept, 16 divide steps, commit
    localparam int IDLE_PERCENT = 26;

    // one expected result word
    typedef struct {
        logic [IDX_W-1:0] index;
        logic [AVG_W-1:0] average;
        logic [AVG_W-1:0] history;
        logic onset;
    } window_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // input stream
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [SAMPLE_W-1:0] s_tdata = '0;  // [15:0] sample
    logic s_tlast = 1'b0;               // last_of_block

    // output stream
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;  // [15:0] window_index, [31:16] window_average,
                                     // [47:32] history_average
    logic [0:0] m_tuser;             // [0] is_outlier

    // configuration port
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    // predictor copy of the registers
    logic [LEN_W-1:0] cfg_window_length = 13'd1024;
    logic [THR_W-1:0] cfg_threshold = 16'd3277;

    // predictor copy of the detector state
    int unsigned acc_sum = 0;
    int unsigned acc_count = 0;
    logic [AVG_W-1:0] avg_ring [HISTORY_DEPTH];
    int unsigned ring_total = 0;
    int unsigned ring_pos = 0;
    logic [IDX_W-1:0] block_window_idx = '0;

    window_report_t pending_reports[$];
    window_report_t head_report;

    // run bookkeeping
    bit no_idle = 1'b0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned samples_sent = 0;
    int unsigned blocks_sent = 0;
    int unsigned settings_applied = 0;
    int unsigned words_checked = 0;
    int unsigned onsets_seen = 0;

    energy_onset_detector_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, pending_reports.size());
            $display("energy_onset_detector_top regression: fail");
            $finish;
        end
    end

    function automatic void report_failure(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
            report_failure($sformatf("%s expected %0d got %0d", name, want, got));
    endfunction

    // predictor: folds one accepted sample into the window and queues the
    // report when the window closes
    task automatic predict_sample(input logic [SAMPLE_W-1:0] smp, input logic lst);
        logic [MAG_W-1:0] mag;
        int unsigned eff_len;
        int unsigned avg;
        int unsigned hist;
        window_report_t rep;
        // most negative sample gives a magnitude of 32768
        if (smp[SAMPLE_W-1])
            mag = 17'h10000 - {1'b0, smp};
        else
            mag = {1'b0, smp};
        acc_sum += mag;
        acc_count++;
        // zero length acts as one, long lengths saturate
        if (cfg_window_length == 0)
            eff_len = 1;
        else if (cfg_window_length > MAX_WINDOW_LENGTH)
            eff_len = MAX_WINDOW_LENGTH;
        else
            eff_len = cfg_window_length;
        // a shortened length closes the window as soon as the count reaches it
        if (lst || acc_count >= eff_len)
        begin
            avg = acc_sum / acc_count;
            hist = ring_total / HISTORY_DEPTH;
            rep.index = block_window_idx;
            rep.average = avg[AVG_W-1:0];
            rep.history = hist[AVG_W-1:0];
            rep.onset = (int'(avg) - int'(hist)) >= int'(cfg_threshold);
            pending_reports.insert(pending_reports.size(), rep);
            if (lst)
            begin
                foreach (avg_ring[i])
                    avg_ring[i] = '0;
                ring_total = 0;
                ring_pos = 0;
                block_window_idx = '0;
            end
            else
            begin
                ring_total = ring_total - avg_ring[ring_pos] + avg;
                avg_ring[ring_pos] = avg[AVG_W-1:0];
                ring_pos = (ring_pos + 1) % HISTORY_DEPTH;
                block_window_idx = block_window_idx + 1'b1;
            end
            acc_sum = 0;
            acc_count = 0;
        end
    endtask

    // output side: random back-pressure and the compare against the oldest report
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_reports.size() == 0)
                report_failure($sformatf("unexpected window word %h user %b",
                                         m_tdata, m_tuser));
            else
            begin
                head_report = pending_reports.pop_front();
                check_field("window_index", head_report.index, m_tdata[IDX_W-1:0]);
                check_field("window_average", head_report.average,
                            m_tdata[IDX_W +: AVG_W]);
                check_field("history_average", head_report.history,
                            m_tdata[IDX_W+AVG_W +: AVG_W]);
                check_field("is_outlier", head_report.onset, m_tuser[0]);
            end
            words_checked++;
            if (m_tuser[0])
                onsets_seen++;
        end
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // sends one word and waits for the handshake, then maybe idles a while
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic lst);
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        s_tlast <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        samples_sent++;
        predict_sample(smp, lst);
        if (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= $urandom;
            s_tlast <= $urandom_range(0, 1);
            do
                @(posedge clk);
            while ($urandom_range(99) < IDLE_PERCENT);
        end
    endtask

    // stop sending until every expected word is back and the divider is quiet
    task automatic wait_for_reports();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic apb_write(input eod_reg_idx_t idx, input logic [APB_DW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (idx == REG_WINDOW_LENGTH)
            cfg_window_length = value[LEN_W-1:0];
        else
            cfg_threshold = value[THR_W-1:0];
    endtask

    task automatic apb_read(input eod_reg_idx_t idx, output logic [APB_DW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        value = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_registers();
        logic [APB_DW-1:0] rd;
        apb_read(REG_WINDOW_LENGTH, rd);
        check_field("window_length readback", cfg_window_length, rd);
        apb_read(REG_THRESHOLD, rd);
        check_field("threshold readback", cfg_threshold, rd);
    endtask

    // new register values, only with the block idle; order of the writes is random
    task automatic write_settings(input logic [APB_DW-1:0] len, input logic [APB_DW-1:0] thr);
        wait_for_reports();
        if ($urandom_range(0, 1))
        begin
            apb_write(REG_WINDOW_LENGTH, len);
            apb_write(REG_THRESHOLD, thr);
        end
        else
        begin
            apb_write(REG_THRESHOLD, thr);
            apb_write(REG_WINDOW_LENGTH, len);
        end
        check_registers();
        settings_applied++;
    endtask

    // a run of samples with quiet, medium and loud stretches so that onsets occur
    task automatic send_block(input int unsigned n_samples, input bit close_block);
        int unsigned seg_left;
        int unsigned amp;
        int unsigned mag;
        bit loud;
        logic [SAMPLE_W-1:0] smp;
        seg_left = 0;
        amp = 0;
        loud = 1'b0;
        for (int unsigned i = 0; i < n_samples; i++)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(1, 32);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin amp = 300; loud = 1'b0; end
                    5, 6, 7:       begin amp = 4000; loud = 1'b0; end
                    default:       begin amp = 0; loud = 1'b1; end
                endcase
            end
            seg_left--;
            if (loud)
                smp = $urandom;
            else
            begin
                mag = $urandom_range(0, amp);
                smp = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
            end
            send_sample(smp, close_block && (i == n_samples - 1));
        end
        if (close_block)
            blocks_sent++;
    endtask

    task automatic test_register_defaults();
        check_registers();
    endtask

    // partial window at the default length, closed by the block end
    task automatic test_default_block();
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        blocks_sent++;
    endtask

    // zero length acts as one sample per window, zero threshold
    task automatic test_single_sample_windows();
        write_settings(32'd0, 32'd0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h8000, 1'b1);
        blocks_sent++;
    endtask

    // length shortened while a window is half full
    task automatic test_length_change();
        write_settings(32'd5, 32'd32768);
        send_sample(16'h4000, 1'b0);
        send_sample(16'hC000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        write_settings(32'd2, 32'd32768);
        send_sample(16'h0100, 1'b0);
        send_sample(16'hFF00, 1'b1);
        blocks_sent++;
    endtask

    // all-ones writes: length saturates to the maximum window, threshold never met
    task automatic test_long_window();
        write_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_block(MAX_WINDOW_LENGTH + 3, 1'b1);
    endtask

    // several register settings, mostly well-formed blocks with random content;
    // some blocks run on without an end marker
    task automatic test_random_blocks();
        int unsigned phase_items;
        int unsigned n;
        logic [APB_DW-1:0] len;
        logic [APB_DW-1:0] thr;
        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0: begin len = 1; thr = $urandom_range(0, 4000); end
                1: begin len = 2; thr = 0; end
                2: begin len = $urandom_range(3, 8); thr = 32768; end
                3: begin len = 0; thr = $urandom_range(0, 3000); end
                4: begin len = $urandom_range(1, 16); thr = $urandom_range(0, 3000); end
                5: begin len = 64; thr = 1000; end
                6: begin len = MAX_WINDOW_LENGTH; thr = $urandom_range(0, 3000); end
                7: begin len = $urandom_range(9, 40); thr = $urandom_range(0, 6000); end
                8: begin len = 1; thr = 65535; end
                default: begin len = $urandom_range(1, 6); thr = $urandom_range(0, 2000); end
            endcase
            write_settings(len, thr);
            // one whole phase without any idling on either side
            no_idle = (p == 4);
            phase_items = 0;
            while (phase_items < 200)
            begin
                if ($urandom_range(0, 9) == 0)
                    n = $urandom_range(150, 500);
                else
                    n = $urandom_range(1, 120);
                send_block(n, $urandom_range(0, 9) != 0);
                phase_items += n;
                if ($urandom_range(0, 19) == 0)
                    wait_for_reports();
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        foreach (avg_ring[i])
            avg_ring[i] = '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        test_default_block();
        test_single_sample_windows();
        test_length_change();
        test_long_window();
        test_random_blocks();

        wait_for_reports();
        repeat (40)
            @(posedge clk);

        $display("sent %0d samples in %0d closed blocks across %0d register settings",
                 samples_sent, blocks_sent, settings_applied);
        $display("checked %0d window words, %0d of them flagged as onsets",
                 words_checked, onsets_seen);
        if (error_count == 0)
            $display("energy_onset_detector_top regression: pass");
        else
        begin
            $display("%0d mismatches in total", error_count);
            $display("energy_onset_detector_top regression: fail");
        end
        $finish;
    end

endmodule
